@@ rtl/core/pbc_pkg.sv @@
// Shared types and constants for the press-rate lockout button controller.
package pbc_pkg;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 24;
    localparam int unsigned IN_DATA_W  = 8;
    localparam int unsigned OUT_DATA_W = 48;

    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_LIMIT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_MS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_MS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_MS     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SESSION_MAX = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_MS     = 3'd5;

    localparam logic [7:0]  RST_PRESS_LIMIT = 8'd3;
    localparam logic [23:0] RST_WINDOW_MS   = 24'd30000;
    localparam logic [15:0] RST_DEBOUNCE_MS = 16'd50;
    localparam logic [15:0] RST_HOLD_MS     = 16'd2000;
    localparam logic [23:0] RST_SESSION_MAX = 24'd60000;
    localparam logic [23:0] RST_IDLE_MS     = 24'd60000;

    typedef struct packed {
        logic        press_event;
        logic        chime;
        logic [7:0]  press_count;
        logic        locked;
        logic [31:0] sequence_res;
        logic        session_active;
        logic        session_opened;
        logic        session_closed;
        logic        sleep_request;
    } t_result;

endpackage

@@ rtl/core/press_rate_lockout_button_controller.sv @@
// Top level of the press-rate lockout button controller.
//
//  channel   | dir | handshake                      | payload
//  ----------+-----+--------------------------------+---------------------------------
//  s_axis    | in  | s_axis_tvalid / s_axis_tready  | one millisecond tick, button levels
//  m_axis    | out | m_axis_tvalid / m_axis_tready  | one result per tick
//  cfg       | in  | i_cfg_we (no wait)             | register index and value
//
// One tick per cycle unless stalled; result on m_axis at earliest the cycle after its beat.
// The state update is one pass of logic from the state registers to the result register.
// Synchronous active-low reset restores register defaults and clears all state.
// A skid stage holds one extra result, so s_axis stalls only after two waiting results.
module press_rate_lockout_button_controller (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [pbc_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [pbc_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [0] bell_level, [1] talk_level, [7:2] zero
    input  logic [pbc_pkg::IN_DATA_W-1:0]       s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [0] press_event, [1] chime, [9:2] press_count, [10] locked,
    // [42:11] sequence_res, [43] session_active, [44] session_opened,
    // [45] session_closed, [46] sleep_request, [47] zero
    output logic [pbc_pkg::OUT_DATA_W-1:0]      m_axis_tdata
);

    logic             beat;
    pbc_pkg::t_result res;
    pbc_pkg::t_result out_res;

    assign beat = s_axis_tvalid & s_axis_tready;

    pbc_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_beat     (beat),
        .i_bell     (s_axis_tdata[0]),
        .i_talk     (s_axis_tdata[1]),
        .o_res      (res)
    );

    pbc_obuf u_obuf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_in_data   (res),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (out_res)
    );

    assign m_axis_tdata = {1'b0,
                           out_res.sleep_request,
                           out_res.session_closed,
                           out_res.session_opened,
                           out_res.session_active,
                           out_res.sequence_res,
                           out_res.locked,
                           out_res.press_count,
                           out_res.chime,
                           out_res.press_event};

endmodule

@@ rtl/core/pbc_core.sv @@
// Tick processing: debounce, press window, lockout, session and idle state.
module pbc_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [pbc_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [pbc_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                i_beat,
    input  logic                                i_bell,
    input  logic                                i_talk,
    output pbc_pkg::t_result                    o_res
);

    logic [7:0]  r_limit;
    logic [23:0] r_window;
    logic [15:0] r_debounce;
    logic [15:0] r_hold;
    logic [23:0] r_smax;
    logic [23:0] r_idle;

    logic [31:0] r_now, n_now;
    logic [31:0] r_win_start, n_win_start;
    logic [31:0] r_last_act, n_last_act;
    logic [31:0] r_sess_start, n_sess_start;
    logic [31:0] r_edge_time, n_edge_time;
    logic [31:0] r_talk_time, n_talk_time;
    logic [31:0] r_seq, n_seq;
    logic [7:0]  r_count, n_count;
    logic        r_bell_last, n_bell_last;
    logic        r_talk_down, n_talk_down;
    logic        r_in_sess, n_in_sess;
    logic        r_lock, n_lock;
    logic        r_asleep, n_asleep;

    logic [7:0]  cnt0;
    logic [7:0]  cnt1;
    logic        lock0;
    logic        lock1;
    logic        press;
    logic        win_exp;
    logic        opened;
    logic        closed;
    logic        sess1;
    logic        sleep_req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit    <= pbc_pkg::RST_PRESS_LIMIT;
            r_window   <= pbc_pkg::RST_WINDOW_MS;
            r_debounce <= pbc_pkg::RST_DEBOUNCE_MS;
            r_hold     <= pbc_pkg::RST_HOLD_MS;
            r_smax     <= pbc_pkg::RST_SESSION_MAX;
            r_idle     <= pbc_pkg::RST_IDLE_MS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                pbc_pkg::CFG_PRESS_LIMIT: r_limit    <= i_cfg_data[7:0];
                pbc_pkg::CFG_WINDOW_MS:   r_window   <= i_cfg_data;
                pbc_pkg::CFG_DEBOUNCE_MS: r_debounce <= i_cfg_data[15:0];
                pbc_pkg::CFG_HOLD_MS:     r_hold     <= i_cfg_data[15:0];
                pbc_pkg::CFG_SESSION_MAX: r_smax     <= i_cfg_data;
                pbc_pkg::CFG_IDLE_MS:     r_idle     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_now        = r_now;
        n_win_start  = r_win_start;
        n_last_act   = r_last_act;
        n_sess_start = r_sess_start;
        n_edge_time  = r_edge_time;
        n_talk_time  = r_talk_time;
        n_seq        = r_seq;
        n_count      = r_count;
        n_bell_last  = r_bell_last;
        n_talk_down  = r_talk_down;
        n_in_sess    = r_in_sess;
        n_lock       = r_lock;
        n_asleep     = r_asleep;
        o_res        = '0;

        // bell debounce and press
        press   = 1'b0;
        win_exp = (r_now - r_win_start) > {8'd0, r_window};
        cnt0    = win_exp ? 8'd0 : r_count;
        lock0   = win_exp ? 1'b0 : r_lock;
        cnt1    = (cnt0 < r_limit) ? cnt0 + 8'd1 : cnt0;
        lock1   = lock0 | (cnt1 >= r_limit);
        if (i_bell != r_bell_last && (r_now - r_edge_time) > {16'd0, r_debounce}) begin
            n_edge_time = r_now;
            n_bell_last = i_bell;
            if (i_bell && !r_in_sess) begin
                press      = 1'b1;
                n_last_act = r_now;
                n_count    = cnt1;
                n_lock     = lock1;
                n_seq      = r_seq + 32'd1;
                if (win_exp) begin
                    n_win_start = r_now;
                end
            end
        end

        // talk tracking and session open
        n_talk_down = i_talk;
        if (i_talk && !r_talk_down) begin
            n_talk_time = r_now;
        end
        opened = i_talk && !r_in_sess && (r_now - n_talk_time) >= {16'd0, r_hold};
        sess1  = r_in_sess | opened;
        if (opened) begin
            n_sess_start = r_now;
        end

        // session run and close
        closed = 1'b0;
        if (sess1) begin
            n_last_act = r_now;
            if (!i_talk || (r_now - n_sess_start) > {8'd0, r_smax}) begin
                closed      = 1'b1;
                n_win_start = r_now;
                n_count     = 8'd0;
                n_lock      = 1'b0;
            end
        end
        n_in_sess = sess1 & ~closed;

        // idle timeout
        sleep_req = !n_in_sess && (r_now - n_last_act) > {8'd0, r_idle};
        n_asleep  = sleep_req;
        n_now     = r_now + 32'd1;

        o_res.press_event    = press;
        o_res.chime          = press & ~lock1;
        o_res.press_count    = n_count;
        o_res.locked         = n_lock;
        o_res.sequence_res   = press ? n_seq : 32'd0;
        o_res.session_active = n_in_sess;
        o_res.session_opened = opened;
        o_res.session_closed = closed;
        o_res.sleep_request  = sleep_req;

        // asleep: state frozen, sleep request only
        if (r_asleep) begin
            n_now        = r_now;
            n_win_start  = r_win_start;
            n_last_act   = r_last_act;
            n_sess_start = r_sess_start;
            n_edge_time  = r_edge_time;
            n_talk_time  = r_talk_time;
            n_seq        = r_seq;
            n_count      = r_count;
            n_bell_last  = r_bell_last;
            n_talk_down  = r_talk_down;
            n_in_sess    = r_in_sess;
            n_lock       = r_lock;
            n_asleep     = 1'b1;
            o_res               = '0;
            o_res.sleep_request = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_now        <= '0;
            r_win_start  <= '0;
            r_last_act   <= '0;
            r_sess_start <= '0;
            r_edge_time  <= '0;
            r_talk_time  <= '0;
            r_seq        <= '0;
            r_count      <= '0;
            r_bell_last  <= 1'b0;
            r_talk_down  <= 1'b0;
            r_in_sess    <= 1'b0;
            r_lock       <= 1'b0;
            r_asleep     <= 1'b0;
        end else if (i_beat) begin
            r_now        <= n_now;
            r_win_start  <= n_win_start;
            r_last_act   <= n_last_act;
            r_sess_start <= n_sess_start;
            r_edge_time  <= n_edge_time;
            r_talk_time  <= n_talk_time;
            r_seq        <= n_seq;
            r_count      <= n_count;
            r_bell_last  <= n_bell_last;
            r_talk_down  <= n_talk_down;
            r_in_sess    <= n_in_sess;
            r_lock       <= n_lock;
            r_asleep     <= n_asleep;
        end
    end

endmodule

@@ rtl/core/pbc_obuf.sv @@
// Result register with a skid stage toward the output stream.
module pbc_obuf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  pbc_pkg::t_result i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output pbc_pkg::t_result o_out_data
);

    logic             r_out_v, n_out_v;
    logic             r_skid_v, n_skid_v;
    pbc_pkg::t_result r_out, n_out;
    pbc_pkg::t_result r_skid, n_skid;
    logic             push;
    logic             pop;

    assign o_in_ready  = ~r_skid_v;
    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out;
    assign push        = i_in_valid & ~r_skid_v;
    assign pop         = r_out_v & i_out_ready;

    always_comb begin
        n_out_v  = r_out_v;
        n_skid_v = r_skid_v;
        n_out    = r_out;
        n_skid   = r_skid;
        if (pop) begin
            if (r_skid_v) begin
                n_out    = r_skid;
                n_skid_v = 1'b0;
            end else begin
                n_out_v = push;
                n_out   = i_in_data;
            end
        end else if (push) begin
            if (!r_out_v) begin
                n_out_v = 1'b1;
                n_out   = i_in_data;
            end else begin
                n_skid_v = 1'b1;
                n_skid   = i_in_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            r_out_v  <= n_out_v;
            r_skid_v <= n_skid_v;
        end
        r_out  <= n_out;
        r_skid <= n_skid;
    end

endmodule

@@ rtl/core/pbc_checker.sv @@
// Port-level checks for the press-rate lockout button controller, with bind.
module pbc_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [pbc_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled beat changed");

    a_chime_press: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[1] |-> m_axis_tdata[0] && !m_axis_tdata[10])
        else $error("chime without unlocked press");

    a_open_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[44] |-> m_axis_tdata[43] && !m_axis_tdata[45])
        else $error("session opened but not active");

endmodule

bind press_rate_lockout_button_controller pbc_checker u_pbc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

@@ tb/tb_press_rate_lockout_button_controller.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the press-rate lockout button controller.
module tb_press_rate_lockout_button_controller;

    localparam logic [pbc_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [pbc_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    typedef struct packed {
        bit        bell;
        bit        talk;
        bit        fixed;
        bit        press;
        bit        chime;
        bit [7:0]  count;
        bit        locked;
        bit [31:0] seq;
    } t_dir_row;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_cfg_we = 1'b0;
    logic [pbc_pkg::CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [pbc_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    // [0] bell_level, [1] talk_level, [7:2] zero
    logic [pbc_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    // [0] press_event, [1] chime, [9:2] press_count, [10] locked,
    // [42:11] sequence_res, [43] session_active, [44] session_opened,
    // [45] session_closed, [46] sleep_request, [47] zero
    logic [pbc_pkg::OUT_DATA_W-1:0] m_axis_tdata;

    press_rate_lockout_button_controller dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // register mirror
    bit [7:0]  lim_cfg  = pbc_pkg::RST_PRESS_LIMIT;
    bit [23:0] win_cfg  = pbc_pkg::RST_WINDOW_MS;
    bit [15:0] deb_cfg  = pbc_pkg::RST_DEBOUNCE_MS;
    bit [15:0] hold_cfg = pbc_pkg::RST_HOLD_MS;
    bit [23:0] smax_cfg = pbc_pkg::RST_SESSION_MAX;
    bit [23:0] idle_cfg = pbc_pkg::RST_IDLE_MS;

    // controller state
    bit [31:0] tick_now     = '0;
    bit [31:0] win_start    = '0;
    bit [31:0] last_busy    = '0;
    bit [31:0] sess_start   = '0;
    bit [31:0] bell_edge_at = '0;
    bit [31:0] talk_since   = '0;
    bit        bell_seen    = 1'b0;
    bit        talk_held    = 1'b0;
    bit        sess_open    = 1'b0;
    bit        lockout      = 1'b0;
    bit        dozing       = 1'b0;
    bit [7:0]  press_cnt    = '0;
    bit [31:0] seq_cnt      = '0;

    pbc_pkg::t_result predicted_results[$];
    int      mismatches = 0;
    bit      gaps_on = 1'b1;
    bit      stall_on = 1'b1;
    bit      hold_off_req = 1'b0;
    bit      bell_now = 1'b0;

    t_dir_row dir_rows [25] = '{
        '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 8'd0, 1'b0, 32'd0},
        '{1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 8'd1, 1'b0, 32'd1},
        '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0, 1'b0, 32'd0},
        '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 8'd2, 1'b1, 32'd2},
        '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0, 1'b0, 32'd0},
        '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 8'd2, 1'b1, 32'd3},
        '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0, 1'b0, 32'd0},
        '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0, 1'b0, 32'd0},
        '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0, 1'b0, 32'd0},
        '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0, 1'b0, 32'd0},
        '{1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 8'd0, 1'b0, 32'd0},
        '{1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 8'd0, 1'b0, 32'd0},
        '{1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 8'd0, 1'b0, 32'd0},
        '{1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 8'd0, 1'b0, 32'd0},
        '{1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 8'd0, 1'b0, 32'd0},
        '{1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 8'd0, 1'b0, 32'd0},
        '{1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 8'd0, 1'b0, 32'd0},
        '{1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 8'd0, 1'b0, 32'd0},
        '{1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 8'd0, 1'b0, 32'd0},
        '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0, 1'b0, 32'd0},
        '{1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 8'd0, 1'b0, 32'd0},
        '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0, 1'b0, 32'd0},
        '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0, 1'b0, 32'd0},
        '{1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 8'd0, 1'b0, 32'd0},
        '{1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 8'd0, 1'b0, 32'd0}
    };

    function automatic pbc_pkg::t_result predict_tick(bit bell, bit talk);
        pbc_pkg::t_result r;
        bit [31:0]        t;
        r = '0;
        t = tick_now;
        if (dozing) begin
            r.sleep_request = 1'b1;
            return r;
        end
        if (bell != bell_seen && (t - bell_edge_at) > deb_cfg) begin
            bell_edge_at = t;
            bell_seen = bell;
            if (bell && !sess_open) begin
                last_busy = t;
                if ((t - win_start) > win_cfg) begin
                    press_cnt = '0;
                    lockout = 1'b0;
                    win_start = t;
                end
                if (press_cnt < lim_cfg)
                    press_cnt = press_cnt + 8'd1;
                if (press_cnt >= lim_cfg)
                    lockout = 1'b1;
                seq_cnt = seq_cnt + 32'd1;
                r.press_event = 1'b1;
                r.chime = !lockout;
                r.sequence_res = seq_cnt;
            end
        end
        if (talk && !talk_held) begin
            talk_held = 1'b1;
            talk_since = t;
        end
        if (!talk && talk_held)
            talk_held = 1'b0;
        if (talk_held && !sess_open && (t - talk_since) >= hold_cfg) begin
            sess_open = 1'b1;
            sess_start = t;
            last_busy = t;
            r.session_opened = 1'b1;
        end
        if (sess_open) begin
            last_busy = t;
            if (!talk || (t - sess_start) > smax_cfg) begin
                sess_open = 1'b0;
                win_start = t;
                press_cnt = '0;
                lockout = 1'b0;
                r.session_closed = 1'b1;
            end
        end
        if (!sess_open && (t - last_busy) > idle_cfg) begin
            dozing = 1'b1;
            r.sleep_request = 1'b1;
        end
        tick_now = t + 32'd1;
        r.press_count = press_cnt;
        r.locked = lockout;
        r.session_active = sess_open;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [47:0] got, logic [47:0] want);
        $display("%0t: %s mismatch, got 0x%0h expected 0x%0h", $time, what, got, want);
        mismatches++;
    endtask

    task automatic compare_field(string what, logic [47:0] got, logic [47:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    always @(posedge i_clk) begin : result_check
        pbc_pkg::t_result got;
        pbc_pkg::t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.press_event    = m_axis_tdata[0];
            got.chime          = m_axis_tdata[1];
            got.press_count    = m_axis_tdata[9:2];
            got.locked         = m_axis_tdata[10];
            got.sequence_res   = m_axis_tdata[42:11];
            got.session_active = m_axis_tdata[43];
            got.session_opened = m_axis_tdata[44];
            got.session_closed = m_axis_tdata[45];
            got.sleep_request  = m_axis_tdata[46];
            if (predicted_results.size() == 0) begin
                report_mismatch("unexpected result", m_axis_tdata, '0);
            end else begin
                want = predicted_results.pop_front();
                compare_field("press_event", 48'(got.press_event), 48'(want.press_event));
                compare_field("chime", 48'(got.chime), 48'(want.chime));
                compare_field("press_count", 48'(got.press_count), 48'(want.press_count));
                compare_field("locked", 48'(got.locked), 48'(want.locked));
                compare_field("sequence_res", 48'(got.sequence_res),
                              48'(want.sequence_res));
                compare_field("session_active", 48'(got.session_active),
                              48'(want.session_active));
                compare_field("session_opened", 48'(got.session_opened),
                              48'(want.session_opened));
                compare_field("session_closed", 48'(got.session_closed),
                              48'(want.session_closed));
                compare_field("sleep_request", 48'(got.sleep_request),
                              48'(want.sleep_request));
                compare_field("pad", 48'(m_axis_tdata[47]), 48'd0);
            end
        end
    end

    // result side: random stall bursts, plus one long hold-off on request
    initial begin : result_sink
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                stall_left = 40;
            end
            if (stall_left > 0) begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end else if (stall_on && $urandom_range(0, 5) == 0) begin
                m_axis_tready <= 1'b0;
                stall_left = $urandom_range(0, 6);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic send_tick(bit bell, bit talk, bit fixed = 1'b0,
                             pbc_pkg::t_result fixed_res = '0);
        pbc_pkg::t_result predicted;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {{(pbc_pkg::IN_DATA_W-2){1'b0}}, talk, bell};
        do @(posedge i_clk); while (!s_axis_tready);
        predicted = predict_tick(bell, talk);
        predicted_results.push_back(fixed ? fixed_res : predicted);
        if (gaps_on && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (predicted_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [pbc_pkg::CFG_IDX_W-1:0] idx,
                             logic [pbc_pkg::CFG_DATA_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            pbc_pkg::CFG_PRESS_LIMIT: lim_cfg  = data[7:0];
            pbc_pkg::CFG_WINDOW_MS:   win_cfg  = data[23:0];
            pbc_pkg::CFG_DEBOUNCE_MS: deb_cfg  = data[15:0];
            pbc_pkg::CFG_HOLD_MS:     hold_cfg = data[15:0];
            pbc_pkg::CFG_SESSION_MAX: smax_cfg = data[23:0];
            pbc_pkg::CFG_IDLE_MS:     idle_cfg = data[23:0];
            default: ;
        endcase
    endtask

    // narrow registers get junk in the unused upper data bits
    task automatic set_phase(bit [7:0] lim, bit [23:0] win, bit [15:0] deb,
                             bit [15:0] hold, bit [23:0] smax, bit [23:0] idle);
        logic [23:0] junk;
        drain_results();
        repeat (4) @(posedge i_clk);
        junk = 24'($urandom());
        write_reg(pbc_pkg::CFG_PRESS_LIMIT, {junk[23:8], lim});
        write_reg(pbc_pkg::CFG_WINDOW_MS, win);
        write_reg(pbc_pkg::CFG_DEBOUNCE_MS, {junk[23:16], deb});
        write_reg(pbc_pkg::CFG_HOLD_MS, {junk[15:8], hold});
        write_reg(pbc_pkg::CFG_SESSION_MAX, smax);
        write_reg(pbc_pkg::CFG_IDLE_MS, idle);
        write_reg(junk[0] ? CFG_SPARE_HI : CFG_SPARE_LO, junk);
        i_cfg_we <= 1'b0;
    endtask

    // bell press/release runs, talk holds with presses inside, and noise
    task automatic run_phase(int n_ticks, int talk_pct);
        int sent;
        int len;
        int span;
        int pick;
        sent = 0;
        while (sent < n_ticks) begin
            pick = $urandom_range(0, 99);
            if (pick < talk_pct) begin
                span = int'(hold_cfg) + int'(smax_cfg);
                if (span > 40)
                    span = 40;
                len = $urandom_range(1, span + 8);
                repeat (len) begin
                    if ($urandom_range(0, 3) == 0)
                        bell_now = !bell_now;
                    send_tick(bell_now, 1'b1);
                end
                repeat ($urandom_range(1, 3)) send_tick(bell_now, 1'b0);
                sent += len + 1;
            end else if (pick < 85) begin
                span = (deb_cfg < 12) ? int'(deb_cfg) : 12;
                len = $urandom_range(1, 2 * span + 2);
                bell_now = !bell_now;
                repeat (len) send_tick(bell_now, $urandom_range(0, 19) == 0);
                sent += len;
            end else begin
                len = $urandom_range(1, 6);
                repeat (len) begin
                    bell_now = 1'($urandom_range(0, 1));
                    send_tick(bell_now, 1'($urandom_range(0, 1)));
                end
                sent += len;
            end
        end
    endtask

    initial begin : run_watchdog
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    initial begin : stimulus
        t_dir_row         row;
        pbc_pkg::t_result fixed_res;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_phase(8'd2, 24'd8, 16'd0, 16'd2, 24'd4, 24'hFFFFFF);
        foreach (dir_rows[i]) begin
            row = dir_rows[i];
            fixed_res = '0;
            fixed_res.press_event = row.press;
            fixed_res.chime = row.chime;
            fixed_res.press_count = row.count;
            fixed_res.locked = row.locked;
            fixed_res.sequence_res = row.seq;
            send_tick(row.bell, row.talk, row.fixed, fixed_res);
        end

        set_phase(8'd3, 24'd40, 16'd3, 16'd5, 24'd20, 24'd60000);
        run_phase(120, 20);
        // back-to-back beats into a long output hold-off
        gaps_on = 1'b0;
        hold_off_req = 1'b1;
        run_phase(30, 20);
        gaps_on = 1'b1;
        drain_results();
        run_phase(100, 20);

        set_phase(8'd255, 24'hFFFFFF, 16'd0, 16'd0, 24'd0, 24'hFFFFFF);
        run_phase(150, 30);

        // build up the count, then drop the limit below it
        set_phase(8'd8, 24'hFFFFFF, 16'd1, 16'd4, 24'd12, 24'd100000);
        run_phase(120, 0);
        set_phase(8'd2, 24'hFFFFFF, 16'd1, 16'd4, 24'd12, 24'd100000);
        run_phase(40, 0);

        set_phase(8'd0, 24'd20, 16'd2, 16'd3, 24'd10, 24'd70000);
        run_phase(100, 20);

        set_phase(8'd1, 24'd0, 16'hFFFF, 16'hFFFF, 24'hFFFFFF, 24'd30000);
        run_phase(60, 30);

        for (int p = 0; p < 4; p++) begin
            set_phase(8'($urandom_range(0, 8)), 24'($urandom_range(0, 60)),
                      16'($urandom_range(0, 6)), 16'($urandom_range(0, 8)),
                      24'($urandom_range(0, 25)),
                      24'($urandom_range(5000, 24'hFFFFFF)));
            gaps_on = p[0];
            stall_on = !p[1];
            run_phase(120, 25);
        end

        // no idling from here; sessions cycle, then inactivity puts it to sleep
        gaps_on = 1'b0;
        stall_on = 1'b0;
        set_phase(8'd3, 24'd100, 16'd1, 16'd0, 24'd10, 24'd0);
        repeat (15) send_tick(1'($urandom_range(0, 1)), 1'b1);
        repeat (25) send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        repeat (5) send_tick(1'b0, 1'b0);
        repeat (20) send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));

        drain_results();
        repeat (5) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
